[rtl/raster_cluster_labeler_unit_defines.svh]
// Assertion macros for the raster cluster labeller.
// Included by the top level; needs no other file.
`ifndef RASTER_CLUSTER_LABELER_UNIT_DEFINES_SVH
`define RASTER_CLUSTER_LABELER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RCL_ASSERT_ALWAYS(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rcl: invariant violated");
`define RCL_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcl: implication violated");
`else
`define RCL_ASSERT_ALWAYS(name, clk, rst, cond)
`define RCL_ASSERT_IMPLIES(name, clk, rst, ante, cons)
`endif
`endif

[rtl/rcl_pkg.sv]
// Shared types and constants of the raster cluster labeller.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps
package rcl_pkg;
  localparam int GRID_SIDE_W = 7;
  localparam int INDEX_W     = 12;
  localparam int LABEL_W     = 12;
  localparam int FIRST_LABEL = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic               occupied;
    logic [INDEX_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               complete;
    logic               overflow;
  } out_item_t;
endpackage

[rtl/rcl_if.sv]
// Handshake channels of the raster cluster labeller: command, result, config.
// Depends on rcl_pkg.
`timescale 1ns / 1ps
interface rcl_in_if;
  logic             valid;
  logic             ready;
  rcl_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rcl_out_if;
  logic               valid;
  logic               ready;
  rcl_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rcl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rcl_pkg::GRID_SIDE_W-1:0]     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/raster_cluster_labeler_unit.sv]
// Raster cluster labeller (Hoshen-Kopelman) top level.
// Depends on rcl_pkg, rcl_if.sv and raster_cluster_labeler_unit_defines.svh.
//
// Usage:
//   cmd channel: one transaction per command. A load places the next site of
//   the grid in raster order and gives no result; a read returns the resolved
//   label of cell_index on the result channel, with the grid-complete and
//   label-overflow flags.
//   cfg channel: writes grid_side, always ready; write it only while idle.
//   The command channel drops ready for one cycle after a config write.
// Sequence:
//   An empty load visits the site state only. An occupied load with no
//   labelled neighbour visits the site, upper and evaluate states; otherwise
//   a root search follows, one link followed per step (two searches when
//   both neighbours carry a label). A load after a side change first runs a
//   remainder pass to find the column. A read outside the grid or of a site
//   not yet loaded goes straight to the output; any other read looks up the
//   site label first and adds the root search if it is not empty. Each link
//   step is one read of the link memory, whose registered read sets the pace.
// Reset: grid_side = MAX_SIDE, empty grid, labels restart at 2. The link
//   memory needs no clearing pass: every fresh label writes itself as root.
// Stall: a finished result sits in the output register; the next command is
//   taken meanwhile, and a later read waits until that register frees.
`timescale 1ns / 1ps
`include "raster_cluster_labeler_unit_defines.svh"
module raster_cluster_labeler_unit #(
  parameter int MAX_SIDE    = 64,
  parameter int LABEL_SLOTS = 4096
) (
  input  logic      clk,
  input  logic      rst,
  rcl_in_if.sink    cmd_ch,
  rcl_out_if.source res_ch,
  rcl_cfg_if.sink   cfg
);
  import rcl_pkg::*;

  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int CW    = $clog2(CELLS);
  localparam int CNTW  = CW + 1;
  localparam int LW    = $clog2(LABEL_SLOTS);
  localparam int CMPW  = (CNTW > INDEX_W) ? CNTW : INDEX_W;
  localparam int DCW   = $clog2(CNTW + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIV   = 4'd1;
  localparam logic [3:0] ST_SITE  = 4'd2;
  localparam logic [3:0] ST_UPPER = 4'd3;
  localparam logic [3:0] ST_EVAL  = 4'd4;
  localparam logic [3:0] ST_FIND  = 4'd5;
  localparam logic [3:0] ST_RLAB  = 4'd6;
  localparam logic [3:0] ST_OUT   = 4'd7;

  // memories: per-site label and label parent links
  logic [LW-1:0] site_mem [CELLS];
  logic [LW-1:0] link_mem [LABEL_SLOTS];
  logic [LW-1:0] site_q, link_q;
  logic          site_we, link_we;
  logic [CW-1:0] site_waddr, site_raddr;
  logic [LW-1:0] site_wdata, link_waddr, link_wdata, link_raddr;

  logic [3:0]             state;
  logic [GRID_SIDE_W-1:0] grid_side;
  logic                   cfg_seen;
  logic [SW-1:0]          side;
  logic [CNTW-1:0]        side_sq;
  logic [CNTW-1:0]        sites_loaded;
  logic [LW:0]            next_label;
  logic                   overflow_seen;
  logic                   stale;
  logic [SW-1:0]          col;
  logic                   rowf;
  logic                   occ_q;
  logic                   is_read;
  logic                   both;
  logic                   fphase;
  logic [LW-1:0]          left_lab;
  logic [LW-1:0]          root_a;
  logic [LW-1:0]          fcur;
  logic [LW-1:0]          lab_out;
  logic [SW-1:0]          rem;
  logic [CNTW-1:0]        dsh;
  logic [DCW-1:0]         dcnt;
  logic                   out_valid;
  out_item_t              out_data;

  // combinational helpers
  int              side_clamp;
  logic            cmd_take, complete, rd_ok, find_hit, eval_up_nz;
  logic [SW:0]     div_t;
  logic [SW-1:0]   rem_next;
  logic [LW-1:0]   up_lab, root_lo, root_hi, fresh_lab;
  logic [CMPW-1:0] idx_ext;

  assign cmd_take   = cmd_ch.valid && cmd_ch.ready;
  assign cmd_ch.ready = (state == ST_IDLE) && !cfg_seen;
  assign cfg.ready  = 1'b1;
  assign res_ch.valid = out_valid;
  assign res_ch.data  = out_data;

  assign complete = sites_loaded >= side_sq;
  assign idx_ext  = CMPW'(cmd_ch.data.cell_index);
  assign rd_ok    = (idx_ext < CMPW'(side_sq)) && (idx_ext < CMPW'(sites_loaded));
  assign find_hit = link_q == fcur;
  assign up_lab   = rowf ? site_q : '0;
  assign eval_up_nz = up_lab != '0;
  assign root_lo  = (root_a < fcur) ? root_a : fcur;
  assign root_hi  = (root_a < fcur) ? fcur : root_a;
  assign fresh_lab = (next_label < (LW+1)'(LABEL_SLOTS)) ? next_label[LW-1:0]
                                                         : LW'(LABEL_SLOTS - 1);
  assign div_t    = {rem, dsh[CNTW-1]};
  assign rem_next = (div_t >= {1'b0, side}) ? SW'(div_t - {1'b0, side}) : SW'(div_t);

  always_comb begin
    if (int'(grid_side) < 2) begin
      side_clamp = 2;
    end else if (int'(grid_side) > MAX_SIDE) begin
      side_clamp = MAX_SIDE;
    end else begin
      side_clamp = int'(grid_side);
    end
  end

  // memory port control
  always_comb begin
    site_we    = 1'b0;
    site_waddr = sites_loaded[CW-1:0];
    site_wdata = '0;
    site_raddr = CW'(cmd_ch.data.cell_index);
    link_we    = 1'b0;
    link_waddr = fresh_lab;
    link_wdata = fresh_lab;
    link_raddr = fcur;
    case (state)
      ST_SITE: begin
        site_raddr = CW'(sites_loaded - CNTW'(1));
        if (!occ_q) begin
          site_we = 1'b1;
        end
      end
      ST_UPPER: begin
        site_raddr = CW'(sites_loaded - CNTW'(side));
      end
      ST_EVAL: begin
        if (!eval_up_nz && left_lab == '0) begin
          site_we    = 1'b1;
          site_wdata = fresh_lab;
          // leave the links alone when the last slot is handed out again
          link_we    = next_label < (LW+1)'(LABEL_SLOTS);
        end else if (eval_up_nz) begin
          link_raddr = up_lab;
        end else begin
          link_raddr = left_lab;
        end
      end
      ST_RLAB: begin
        link_raddr = site_q;
      end
      ST_FIND: begin
        if (!find_hit) begin
          link_raddr = link_q;
        end else if (!is_read) begin
          if (both && !fphase) begin
            link_raddr = left_lab;
          end else if (fphase) begin
            site_we    = 1'b1;
            site_wdata = root_lo;
            link_we    = 1'b1;
            link_waddr = root_hi;
            link_wdata = root_lo;
          end else begin
            site_we    = 1'b1;
            site_wdata = fcur;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (site_we) begin
      site_mem[site_waddr] <= site_wdata;
    end
    site_q <= site_mem[site_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_q <= link_mem[link_raddr];
  end

  // geometry is registered from grid_side and follows it in the next cycle
  always_ff @(posedge clk) begin
    side    <= SW'(side_clamp);
    side_sq <= CNTW'(side_clamp * side_clamp);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      grid_side     <= GRID_SIDE_W'(MAX_SIDE);
      cfg_seen      <= 1'b0;
      sites_loaded  <= '0;
      next_label    <= (LW+1)'(FIRST_LABEL);
      overflow_seen <= 1'b0;
      stale         <= 1'b0;
      col           <= '0;
      rowf          <= 1'b0;
      out_valid     <= 1'b0;
      fphase        <= 1'b0;
    end else begin
      cfg_seen <= cfg.valid;
      if (cfg.valid) begin
        grid_side <= cfg.data;
        stale     <= 1'b1;
      end
      if (out_valid && res_ch.ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            is_read <= cmd_ch.data.cmd == CMD_READ;
            occ_q   <= cmd_ch.data.occupied;
            if (cmd_ch.data.cmd == CMD_READ) begin
              lab_out <= '0;
              state   <= rd_ok ? ST_RLAB : ST_OUT;
            end else if (complete) begin
              // start a new grid
              sites_loaded  <= '0;
              next_label    <= (LW+1)'(FIRST_LABEL);
              overflow_seen <= 1'b0;
              col           <= '0;
              rowf          <= 1'b0;
              stale         <= 1'b0;
              state         <= ST_SITE;
            end else if (stale) begin
              rem   <= '0;
              dsh   <= sites_loaded;
              dcnt  <= '0;
              state <= ST_DIV;
            end else begin
              state <= ST_SITE;
            end
          end
        end
        ST_DIV: begin
          rem  <= rem_next;
          dsh  <= {dsh[CNTW-2:0], 1'b0};
          dcnt <= dcnt + DCW'(1);
          if (dcnt == DCW'(CNTW - 1)) begin
            col   <= rem_next;
            rowf  <= sites_loaded >= CNTW'(side);
            stale <= 1'b0;
            state <= ST_SITE;
          end
        end
        ST_SITE: begin
          state <= occ_q ? ST_UPPER : ST_IDLE;
        end
        ST_UPPER: begin
          left_lab <= (col != '0) ? site_q : '0;
          state    <= ST_EVAL;
        end
        ST_EVAL: begin
          fphase <= 1'b0;
          both   <= eval_up_nz && left_lab != '0;
          if (!eval_up_nz && left_lab == '0) begin
            if (next_label < (LW+1)'(LABEL_SLOTS)) begin
              next_label <= next_label + (LW+1)'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            state <= ST_IDLE;
          end else begin
            fcur  <= eval_up_nz ? up_lab : left_lab;
            state <= ST_FIND;
          end
        end
        ST_RLAB: begin
          if (site_q == '0) begin
            state <= ST_OUT;
          end else begin
            fcur  <= site_q;
            state <= ST_FIND;
          end
        end
        ST_FIND: begin
          if (!find_hit) begin
            fcur <= link_q;
          end else if (is_read) begin
            lab_out <= fcur;
            state   <= ST_OUT;
          end else if (both && !fphase) begin
            root_a <= fcur;
            fphase <= 1'b1;
            fcur   <= left_lab;
          end else begin
            fphase <= 1'b0;
            state  <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (!out_valid || res_ch.ready) begin
            out_valid         <= 1'b1;
            out_data.label    <= LABEL_W'(lab_out);
            out_data.complete <= complete;
            out_data.overflow <= overflow_seen;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // advance the raster position at the end of each load
      if (site_we) begin
        sites_loaded <= sites_loaded + CNTW'(1);
        if (col == side - SW'(1)) begin
          col  <= '0;
          rowf <= 1'b1;
        end else begin
          col <= col + SW'(1);
        end
      end
    end
  end

  `RCL_ASSERT_ALWAYS(a_label_floor, clk, rst, next_label >= (LW+1)'(FIRST_LABEL))
  `RCL_ASSERT_IMPLIES(a_ovf_full, clk, rst, overflow_seen, next_label == (LW+1)'(LABEL_SLOTS))
  `RCL_ASSERT_IMPLIES(a_col_range, clk, rst, !stale && state != ST_IDLE, col < side)
endmodule
